// ===== rtl/core/positional_array_list_top_assert.svh =====
// Assertion macros shared by the checker of the positional array list.
`ifndef POSITIONAL_ARRAY_LIST_TOP_ASSERT_SVH
`define POSITIONAL_ARRAY_LIST_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define PAL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define PAL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/pal_pkg.sv =====
// Package: widths, operation and status codes, controller/datapath interface types.
package pal_pkg;

	localparam int DEPTH = 64;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int LEN_W = $clog2(DEPTH + 1);
	localparam int POS_W = $clog2(DEPTH + 2);
	localparam int VAL_W = 32;

	// operation codes
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_DELETE = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_BADPOS = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;

	// memory read address source
	typedef enum logic [1:0] {
		RD_POS,
		RD_CUR_DN,
		RD_CUR_UP
	} rd_sel_t;

	// controller -> datapath
	typedef struct packed {
		logic    load_item;
		logic    chk;
		logic    cur_load;
		logic    cur_inc;
		logic    cur_dec;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    wr_en;
		logic    wr_val;
		logic    cap;
		logic    len_inc;
		logic    len_dec;
		logic    out_load;
	} pal_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [1:0] chk_status;
		logic [1:0] func;
		logic       ins_more;
		logic       del_more;
		logic       out_busy;
	} pal_stat_t;

endpackage

// ===== rtl/core/pal_ctrl.sv =====
// Controller state machine: sequences check, entry moves and result hand-off.
module pal_ctrl import pal_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  pal_stat_t stat,
	output pal_cmd_t  cmd
);

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_CHECK   = 4'd1;
	localparam logic [3:0] S_INS_RD  = 4'd2;
	localparam logic [3:0] S_INS_WR  = 4'd3;
	localparam logic [3:0] S_INS_PUT = 4'd4;
	localparam logic [3:0] S_CAP     = 4'd5;
	localparam logic [3:0] S_DEL_RD  = 4'd6;
	localparam logic [3:0] S_DEL_WR  = 4'd7;
	localparam logic [3:0] S_DONE    = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_nxt;

	assign in_stall = (state_q != S_IDLE);

	// next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		cmd.rd_sel = RD_POS;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_nxt     = S_CHECK;
				end
			end
			S_CHECK: begin
				cmd.chk = 1'b1;
				if (stat.chk_status != ST_OK) begin
					state_nxt = S_DONE;
				end else begin
					case (stat.func)
						OP_INSERT: begin
							cmd.cur_load = 1'b1;
							state_nxt    = S_INS_RD;
						end
						OP_DELETE, OP_READ: begin
							cmd.cur_load = 1'b1;
							cmd.rd_en    = 1'b1;
							cmd.rd_sel   = RD_POS;
							state_nxt    = S_CAP;
						end
						default: state_nxt = S_DONE;
					endcase
				end
			end
			// move one entry up: read below the cursor, then write at the cursor
			S_INS_RD: begin
				if (stat.ins_more) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_CUR_DN;
					state_nxt  = S_INS_WR;
				end else begin
					state_nxt = S_INS_PUT;
				end
			end
			S_INS_WR: begin
				cmd.wr_en   = 1'b1;
				cmd.cur_dec = 1'b1;
				state_nxt   = S_INS_RD;
			end
			S_INS_PUT: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_val  = 1'b1;
				cmd.len_inc = 1'b1;
				state_nxt   = S_DONE;
			end
			S_CAP: begin
				cmd.cap = 1'b1;
				if (stat.func == OP_DELETE) begin
					state_nxt = S_DEL_RD;
				end else begin
					state_nxt = S_DONE;
				end
			end
			// move one entry down: read above the cursor, then write at the cursor
			S_DEL_RD: begin
				if (stat.del_more) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_CUR_UP;
					state_nxt  = S_DEL_WR;
				end else begin
					cmd.len_dec = 1'b1;
					state_nxt   = S_DONE;
				end
			end
			S_DEL_WR: begin
				cmd.wr_en   = 1'b1;
				cmd.cur_inc = 1'b1;
				state_nxt   = S_DEL_RD;
			end
			S_DONE: begin
				if (!stat.out_busy) begin
					cmd.out_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// ===== rtl/core/pal_dpath.sv =====
// Datapath: entry memory, length, cursor, item and result registers.
module pal_dpath import pal_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  pal_cmd_t                cmd,
	output pal_stat_t               stat,
	input  logic [1:0]              func,
	input  logic [POS_W-1:0]        position,
	input  logic signed [VAL_W-1:0] new_value,
	input  logic                    out_stall,
	output logic                    out_valid,
	output logic [1:0]              status,
	output logic signed [VAL_W-1:0] entry_value,
	output logic [LEN_W-1:0]        list_length
);

	logic [VAL_W-1:0] mem [DEPTH];

	logic [1:0]       func_q;
	logic [POS_W-1:0] pos_q;
	logic [VAL_W-1:0] val_q;
	logic [LEN_W-1:0] length_q;
	logic [IDX_W-1:0] cur_q;
	logic [1:0]       status_q;
	logic [VAL_W-1:0] result_q;
	logic [VAL_W-1:0] rd_data_q;
	logic             out_valid_q;
	logic [1:0]       out_status_q;
	logic [VAL_W-1:0] out_value_q;
	logic [LEN_W-1:0] out_len_q;

	logic [POS_W-1:0] pos_m1;
	logic [IDX_W-1:0] pos_idx;
	logic [LEN_W:0]   len_p1;
	logic             full;
	logic             ins_ok;
	logic             sel_ok;
	logic [1:0]       chk_status;
	logic [IDX_W-1:0] rd_addr;
	logic [IDX_W-1:0] wr_addr;
	logic [VAL_W-1:0] wr_data;

	assign pos_m1  = pos_q - POS_W'(1);
	assign pos_idx = pos_m1[IDX_W-1:0];

	// request check: full list first, then position range
	assign len_p1 = {1'b0, length_q} + (LEN_W+1)'(1);
	assign full   = (length_q == LEN_W'(DEPTH));
	assign ins_ok = (pos_q != '0) && ((LEN_W+1)'(pos_q) <= len_p1);
	assign sel_ok = (pos_q != '0) && (LEN_W'(pos_q) <= length_q);

	always_comb begin
		case (func_q)
			OP_INSERT:          chk_status = full ? ST_FULL : (ins_ok ? ST_OK : ST_BADPOS);
			OP_DELETE, OP_READ: chk_status = sel_ok ? ST_OK : ST_BADPOS;
			default:            chk_status = ST_BADPOS;
		endcase
	end

	assign stat.chk_status = chk_status;
	assign stat.func       = func_q;
	assign stat.ins_more   = (POS_W'(cur_q) >= pos_q);
	assign stat.del_more   = ((LEN_W'(cur_q) + LEN_W'(1)) < length_q);
	assign stat.out_busy   = out_valid_q && out_stall;

	// memory addressing
	always_comb begin
		case (cmd.rd_sel)
			RD_POS:    rd_addr = pos_idx;
			RD_CUR_DN: rd_addr = cur_q - IDX_W'(1);
			RD_CUR_UP: rd_addr = cur_q + IDX_W'(1);
			default:   rd_addr = pos_idx;
		endcase
	end

	assign wr_addr = cmd.wr_val ? pos_idx : cur_q;
	assign wr_data = cmd.wr_val ? val_q : rd_data_q;

	// entry memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// item, cursor and result registers
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			func_q <= func;
			pos_q  <= position;
			val_q  <= new_value;
		end
		if (cmd.cur_load) begin
			cur_q <= (func_q == OP_INSERT) ? length_q[IDX_W-1:0] : pos_idx;
		end else if (cmd.cur_inc) begin
			cur_q <= cur_q + IDX_W'(1);
		end else if (cmd.cur_dec) begin
			cur_q <= cur_q - IDX_W'(1);
		end
		if (cmd.chk) begin
			status_q <= chk_status;
			result_q <= '0;
		end else if (cmd.cap) begin
			result_q <= rd_data_q;
		end
		if (cmd.out_load) begin
			out_status_q <= status_q;
			out_value_q  <= result_q;
			out_len_q    <= length_q;
		end
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q <= '0;
		end else if (cmd.len_inc) begin
			length_q <= length_q + LEN_W'(1);
		end else if (cmd.len_dec) begin
			length_q <= length_q - LEN_W'(1);
		end
	end

	// result item valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign entry_value = out_value_q;
	assign list_length = out_len_q;

endmodule

// ===== rtl/core/positional_array_list_top.sv =====
// Top level of the positional array list: controller plus datapath.
//
//   channel | direction | handshake           | payload
//   input   | in        | in_valid, in_stall   | func, position, new_value
//   result  | out       | out_valid, out_stall | status, entry_value, list_length
//
// One item at a time. With list length L and position p, an insert moves
// L-p+1 entries up and a delete moves L-p entries down; each entry moved
// is a read and then a write of the entry memory.
// arst_n clears the length, the controller and the result valid; entries
// are undefined until written. A stalled result holds; the next item is
// taken meanwhile and waits in the controller's final state.
module positional_array_list_top import pal_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [1:0]              func,
	input  logic [POS_W-1:0]        position,
	input  logic signed [VAL_W-1:0] new_value,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [1:0]              status,
	output logic signed [VAL_W-1:0] entry_value,
	output logic [LEN_W-1:0]        list_length
);

	pal_cmd_t  cmd;
	pal_stat_t stat;

	pal_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	pal_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.func        (func),
		.position    (position),
		.new_value   (new_value),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.status      (status),
		.entry_value (entry_value),
		.list_length (list_length)
	);

endmodule

// ===== rtl/core/pal_checker.sv =====
// Port-level checker for the positional array list, bound to the top level.
`include "positional_array_list_top_assert.svh"

module pal_checker import pal_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_stall,
	input logic                    out_valid,
	input logic                    out_stall,
	input logic [1:0]              status,
	input logic signed [VAL_W-1:0] entry_value,
	input logic [LEN_W-1:0]        list_length
);

	// one item at a time: an accepted item stalls the input next cycle
	`PAL_ASSERT_NEXT(a_in_busy, in_valid && !in_stall, in_stall, "input not stalled after item")

	// list never grows past capacity
	`PAL_ASSERT_NOW(a_len_cap, out_valid, list_length <= LEN_W'(DEPTH), "length over capacity")

	// a rejected item returns no entry
	`PAL_ASSERT_NOW(a_reject_zero, out_valid && (status != ST_OK), entry_value == '0, "rejected item carries data")

	// full status only when the list really is full
	`PAL_ASSERT_NOW(a_full_len, out_valid && (status == ST_FULL), list_length == LEN_W'(DEPTH), "full status with room left")

	// a stalled result holds
	`PAL_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(entry_value) && $stable(list_length), "stalled result changed")

endmodule

bind positional_array_list_top pal_checker u_pal_checker (.*);

// ===== tb/positional_array_list_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for positional_array_list_top: predictor, stimulus and result checks.
module positional_array_list_top_tb;
	import pal_pkg::*;

	// code with no operation behind it; the block must reject it
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam int HOLD_OFF_CYCLES = 300;
	// longest items: an insert at the front of a 63-entry list, or a delete at the front of a full one
	localparam int DRAIN_CYCLES = 160;

	typedef struct {
		logic [1:0]              status;
		logic signed [VAL_W-1:0] entry_value;
		logic [LEN_W-1:0]        list_length;
	} list_result_t;

	typedef enum {RX_FREE, RX_LIGHT, RX_HEAVY, RX_BURSTY} rx_mode_e;

	logic                    clk;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic [1:0]              func = OP_READ;
	logic [POS_W-1:0]        position = '0;
	logic signed [VAL_W-1:0] new_value = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic [1:0]              status;
	logic signed [VAL_W-1:0] entry_value;
	logic [LEN_W-1:0]        list_length;

	// predicted list contents and length
	logic signed [VAL_W-1:0] list_mem [DEPTH];
	int                      list_len = 0;
	list_result_t            pending_results [$];

	int       errors = 0;
	int       burst_left = 0;
	int       gap_max = 0;
	int       hold_left = 0;
	rx_mode_e rx_mode = RX_FREE;
	int       op_seen [4] = '{default: 0};
	int       status_seen [3] = '{default: 0};
	int       longest_list = 0;
	int       results_checked = 0;

	positional_array_list_top u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.func        (func),
		.position    (position),
		.new_value   (new_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.entry_value (entry_value),
		.list_length (list_length)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("%0t: timeout, %0d results still expected", $time, pending_results.size());
		$display("positional_array_list_top test failed");
		$finish;
	end

	// Apply one operation to the predicted list and return the result it gives.
	function automatic list_result_t predict_list_op(input logic [1:0] op,
			input logic [POS_W-1:0] pos, input logic signed [VAL_W-1:0] val);
		list_result_t r;
		int p;
		int i;
		p = pos;
		r.status = ST_OK;
		r.entry_value = '0;
		case (op)
			OP_INSERT: begin
				// fullness is checked before the position
				if (list_len >= DEPTH) begin
					r.status = ST_FULL;
				end else if (p < 1 || p > list_len + 1) begin
					r.status = ST_BADPOS;
				end else begin
					for (i = list_len; i > p - 1; i--)
						list_mem[i] = list_mem[i-1];
					list_mem[p-1] = val;
					list_len++;
				end
			end
			OP_DELETE: begin
				if (p < 1 || p > list_len) begin
					r.status = ST_BADPOS;
				end else begin
					r.entry_value = list_mem[p-1];
					for (i = p - 1; i + 1 < list_len; i++)
						list_mem[i] = list_mem[i+1];
					list_len--;
				end
			end
			OP_READ: begin
				if (p < 1 || p > list_len)
					r.status = ST_BADPOS;
				else
					r.entry_value = list_mem[p-1];
			end
			default: begin
				r.status = ST_BADPOS;
			end
		endcase
		r.list_length = LEN_W'(list_len);
		return r;
	endfunction

	// Mostly random words, with the extremes mixed in.
	function automatic logic signed [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return VAL_MAX;
			1: return VAL_MIN;
			2: return '0;
			3: return -1;
			default: return $urandom;
		endcase
	endfunction

	task automatic check_field(input string fld, input longint want, input longint got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, fld, want, got);
			errors++;
		end
	endtask

	// Offer one item, with burst gaps, and record its prediction once accepted.
	task automatic send_item(input logic [1:0] op, input logic [POS_W-1:0] pos,
			input logic signed [VAL_W-1:0] val);
		list_result_t r;
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			if (gap_max > 0) begin
				gap = $urandom_range(1, gap_max);
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		func <= op;
		position <= pos;
		new_value <= val;
		do @(posedge clk); while (in_stall);
		r = predict_list_op(op, pos, val);
		pending_results.push_back(r);
		op_seen[op]++;
		if (r.status <= ST_FULL)
			status_seen[r.status]++;
		if (list_len > longest_list)
			longest_list = list_len;
	endtask

	// Stop offering and wait until every predicted result has come back.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		burst_left = 0;
	endtask

	// Random items: mostly valid positions, grow_pct sets the share of inserts.
	task automatic run_random_ops(input int n, input int grow_pct);
		int k;
		int r;
		logic [1:0] op;
		logic [POS_W-1:0] pos;
		for (k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			if (r < 8) begin
				op = 2'($urandom_range(0, 3));
				pos = POS_W'($urandom_range(0, 127));
			end else begin
				r = $urandom_range(0, 99);
				if (r < grow_pct) begin
					op = OP_INSERT;
					pos = POS_W'($urandom_range(1, list_len + 1));
				end else begin
					op = (r < grow_pct + (100 - grow_pct) * 2 / 3) ? OP_DELETE : OP_READ;
					pos = (list_len == 0) ? POS_W'(1) : POS_W'($urandom_range(1, list_len));
				end
			end
			send_item(op, pos, pick_value());
		end
	endtask

	// Receiver stall pattern, with a counted hold-off on request.
	initial begin
		int run_left;
		logic run_stall;
		run_left = 0;
		run_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				case (rx_mode)
					RX_FREE:  out_stall <= 1'b0;
					RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
					RX_HEAVY: out_stall <= ($urandom_range(0, 2) != 0);
					RX_BURSTY: begin
						if (run_left == 0) begin
							run_stall = ~run_stall;
							run_left = $urandom_range(1, 20);
						end
						run_left--;
						out_stall <= run_stall;
					end
					default:  out_stall <= 1'b0;
				endcase
			end
		end
	end

	// Compare each accepted result with the oldest prediction.
	initial begin
		list_result_t want;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result, status %0d value %0d length %0d",
						$time, status, entry_value, list_length);
					errors++;
				end else begin
					want = pending_results.pop_front();
					check_field("status", want.status, status);
					check_field("entry_value", want.entry_value, entry_value);
					check_field("list_length", want.list_length, list_length);
					results_checked++;
				end
			end
		end
	end

	// Edge positions, every operation and the bad-position rejects on a short list.
	task automatic test_directed();
		int k;
		rx_mode = RX_FREE;
		gap_max = 0;
		send_item(OP_READ, 1, 0);
		send_item(OP_DELETE, 1, 0);
		send_item(OP_INSERT, 0, 5);
		send_item(OP_INSERT, 2, 5);
		send_item(OP_INSERT, 1, VAL_MAX);
		send_item(OP_INSERT, 2, VAL_MIN);
		send_item(OP_INSERT, 1, 0);
		send_item(OP_INSERT, 3, -1);
		send_item(OP_INSERT, 127, 7);
		send_item(OP_UNUSED, 1, 9);
		send_item(OP_UNUSED, 0, VAL_MAX);
		for (k = 1; k <= 4; k++)
			send_item(OP_READ, POS_W'(k), 0);
		send_item(OP_READ, 0, 0);
		send_item(OP_READ, 5, 0);
		send_item(OP_READ, 127, 0);
		send_item(OP_DELETE, 2, 0);
		send_item(OP_DELETE, 3, 0);
		send_item(OP_DELETE, 1, 0);
		send_item(OP_DELETE, 1, 0);
		send_item(OP_DELETE, 0, 0);
		wait_drained();
	endtask

	// Fill to capacity, hit the full case, work both ends of a full list.
	task automatic test_full_list();
		rx_mode = RX_LIGHT;
		gap_max = 4;
		while (list_len < DEPTH)
			send_item(OP_INSERT, POS_W'($urandom_range(1, list_len + 1)), pick_value());
		send_item(OP_INSERT, 1, 11);
		send_item(OP_INSERT, 0, 12);
		send_item(OP_INSERT, 65, 13);
		send_item(OP_INSERT, 127, 14);
		send_item(OP_READ, POS_W'(DEPTH), 0);
		send_item(OP_READ, POS_W'(DEPTH + 1), 0);
		send_item(OP_DELETE, POS_W'(DEPTH), 0);
		send_item(OP_DELETE, 1, 0);
		send_item(OP_INSERT, 1, VAL_MIN);
		send_item(OP_INSERT, 1, VAL_MAX);
		send_item(OP_INSERT, 64, 1);
		send_item(OP_READ, 1, 0);
	endtask

	// Long random stretches under varying idle patterns on both sides.
	task automatic test_random_traffic();
		rx_mode = RX_BURSTY;
		gap_max = 8;
		run_random_ops(150, 45);
		rx_mode = RX_HEAVY;
		gap_max = 2;
		run_random_ops(260, 50);
		rx_mode = RX_LIGHT;
		gap_max = 12;
		run_random_ops(200, 25);
		rx_mode = RX_FREE;
		gap_max = 0;
		run_random_ops(100, 70);
		rx_mode = RX_BURSTY;
		gap_max = 5;
		run_random_ops(100, 40);
	endtask

	// Receiver holds off while the sender keeps offering, then a full pause.
	task automatic test_backpressure();
		rx_mode = RX_FREE;
		gap_max = 0;
		hold_left = HOLD_OFF_CYCLES;
		run_random_ops(12, 50);
		wait_drained();
		rx_mode = RX_LIGHT;
		run_random_ops(10, 50);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_list();
		test_random_traffic();
		test_backpressure();
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Covered %0d inserts, %0d deletes, %0d reads, %0d unused-code items",
			op_seen[OP_INSERT], op_seen[OP_DELETE], op_seen[OP_READ], op_seen[OP_UNUSED]);
		$display("Results checked %0d: %0d ok, %0d bad position, %0d full; longest list %0d",
			results_checked, status_seen[ST_OK], status_seen[ST_BADPOS],
			status_seen[ST_FULL], longest_list);
		if (errors == 0)
			$display("positional_array_list_top test passed");
		else
			$display("positional_array_list_top test failed");
		$finish;
	end

endmodule

// ===== positional_array_list_top.f =====
+incdir+rtl/core
rtl/core/pal_pkg.sv
rtl/core/pal_ctrl.sv
rtl/core/pal_dpath.sv
rtl/core/positional_array_list_top.sv
rtl/core/pal_checker.sv
tb/positional_array_list_top_tb.sv
